// ===== rtl/core/osp_pkg.sv =====
package osp_pkg;

	localparam int MAX_ARGS_DEF   = 8;
	localparam int MAX_BYTES_DEF  = 2048;
	localparam int RES_FIFO_DEPTH = 8;

	typedef enum logic [2:0] {
		KIND_INT    = 3'd0,
		KIND_FLOAT  = 3'd1,
		KIND_STRING = 3'd2,
		KIND_ACCEPT = 3'd3,
		KIND_REJECT = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  arg_number;
		logic [31:0] value_word;
		logic        last_result;
	} res_t;

endpackage

// ===== rtl/core/osc_message_stream_parser.sv =====
// Parses one OSC message per packet, one byte per beat on the slave side with tlast on the
// final byte, and emits a result per decoded argument (int or float raw big-endian word,
// string start offset) followed by an accept or reject result with tlast set. Throughput is
// one byte per clock while tready is high; a byte is registered, processed by the parser
// state logic and its results (at most two) are written to an 8-entry result queue, whose
// head drives the master side. tready drops while the result queue holds more than four
// results, so the master side sets the pace only when it stalls.
module osc_message_stream_parser import osp_pkg::*; #(
	parameter int MaxArgs  = MAX_ARGS_DEF,
	parameter int MaxBytes = MAX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte
	input  logic        s_axis_tlast,  // end_of_packet
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // arg_number, value_word, zero fill
	output logic [2:0]  m_axis_tuser,  // result_kind
	output logic        m_axis_tlast   // last_result
);

	localparam int LVL_W = $clog2(RES_FIFO_DEPTH + 1);
	localparam logic [LVL_W-1:0] READY_LVL = LVL_W'(RES_FIFO_DEPTH - 4);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic [1:0]       res_count;
	res_t             res0;
	res_t             res1;
	res_t             head;
	logic             not_empty;
	logic [LVL_W-1:0] level;
	logic             pop;

	assign s_axis_tready = (level <= READY_LVL);
	assign pop           = not_empty && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		byte_s1 <= s_axis_tdata;
		last_s1 <= s_axis_tlast;
	end

	osp_parser #(
		.MaxArgs  (MaxArgs),
		.MaxBytes (MaxBytes)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.beat_valid    (valid_s1),
		.data_byte     (byte_s1),
		.end_of_packet (last_s1),
		.res_count     (res_count),
		.res0          (res0),
		.res1          (res1)
	);

	osp_res_fifo #(
		.Depth (RES_FIFO_DEPTH)
	) u_res_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (res_count),
		.push0      (res0),
		.push1      (res1),
		.pop        (pop),
		.head       (head),
		.not_empty  (not_empty),
		.level      (level)
	);

	assign m_axis_tvalid = not_empty;
	assign m_axis_tdata  = {4'd0, head.value_word, head.arg_number};
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last_result;

endmodule

// ===== rtl/core/osp_parser.sv =====
module osp_parser import osp_pkg::*; #(
	parameter int MaxArgs  = MAX_ARGS_DEF,
	parameter int MaxBytes = MAX_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       beat_valid,
	input  logic [7:0] data_byte,
	input  logic       end_of_packet,
	output logic [1:0] res_count,
	output res_t       res0,
	output res_t       res1
);

	localparam int CNT_W = $clog2(MaxArgs + 1);
	localparam int IDX_W = (MaxArgs > 1) ? $clog2(MaxArgs) : 1;
	localparam int POS_W = $clog2(MaxBytes + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MaxArgs);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MaxBytes);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_S     = 8'h73;

	typedef enum logic [6:0] {
		PH_ADDR  = 7'b0000001,
		PH_PAD   = 7'b0000010,
		PH_COMMA = 7'b0000100,
		PH_TAGS  = 7'b0001000,
		PH_ARGS  = 7'b0010000,
		PH_DONE  = 7'b0100000,
		PH_ERR   = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		TAG_INT    = 2'd0,
		TAG_FLOAT  = 2'd1,
		TAG_STRING = 2'd2,
		TAG_NONE   = 2'd3
	} tag_t;

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	tag_t             tag_store_q [MaxArgs];
	logic [CNT_W-1:0] tag_cnt_q, tag_cnt_d;
	logic             tag_open_q, tag_open_d;
	logic [CNT_W-1:0] cur_arg_q, cur_arg_d;
	logic [31:0]      word_q, word_d;
	logic [1:0]       wbc_q, wbc_d;
	logic [POS_W-1:0] str_start_q, str_start_d;
	logic [POS_W-1:0] tag_off_q, tag_off_d;

	logic             store_we;
	tag_t             store_code;
	tag_t             cur_kind;
	tag_t             code;
	logic             aligned;
	logic             advance;
	logic             arg_v;
	res_t             arg_res;
	res_t             fin_res;
	logic [POS_W-1:0] start;
	logic [31:0]      word_new;
	logic [31:0]      cur_ext_q;
	logic [31:0]      cur_ext_d;

	assign aligned   = (pos_q[1:0] == 2'b11);
	assign cur_kind  = (cur_arg_q < MAX_CNT) ? tag_store_q[cur_arg_q[IDX_W-1:0]] : TAG_INT;
	assign cur_ext_q = 32'(cur_arg_q);
	assign word_new  = {word_q[23:0], data_byte};

	always_comb begin
		if (data_byte == CH_I) begin
			code = TAG_INT;
		end else if (data_byte == CH_F) begin
			code = TAG_FLOAT;
		end else if (data_byte == CH_S) begin
			code = TAG_STRING;
		end else begin
			code = TAG_NONE;
		end
	end

	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		tag_cnt_d   = tag_cnt_q;
		tag_open_d  = tag_open_q;
		cur_arg_d   = cur_arg_q;
		word_d      = word_q;
		wbc_d       = wbc_q;
		str_start_d = str_start_q;
		tag_off_d   = tag_off_q;
		store_we    = 1'b0;
		store_code  = code;
		advance     = 1'b0;
		arg_v       = 1'b0;
		start       = (wbc_q == 2'd0) ? pos_q : str_start_q;
		arg_res     = '{kind: KIND_INT, arg_number: cur_ext_q[3:0], value_word: word_new,
			last_result: 1'b0};
		if (beat_valid) begin
			if (pos_q >= POS_MAX) begin
				phase_d = PH_ERR;
			end else begin
				pos_d = pos_q + 1'b1;
				unique case (phase_q)
					PH_ADDR: begin
						if (pos_q == '0) begin
							if (data_byte != CH_SLASH) begin
								phase_d = PH_ERR;
							end
						end else if (data_byte == CH_NUL) begin
							phase_d = aligned ? PH_COMMA : PH_PAD;
						end
					end
					PH_PAD: begin
						if (aligned) begin
							phase_d = (tag_off_q == '0) ? PH_COMMA : PH_ARGS;
						end
					end
					PH_COMMA: begin
						if (data_byte == CH_COMMA) begin
							tag_off_d = pos_q;
							phase_d   = PH_TAGS;
						end else begin
							phase_d = PH_ERR;
						end
					end
					PH_TAGS: begin
						if (data_byte == CH_NUL) begin
							if (tag_cnt_q == '0) begin
								phase_d = PH_DONE;
							end else begin
								phase_d = aligned ? PH_ARGS : PH_PAD;
							end
						end else if (tag_open_q) begin
							if (code == TAG_NONE || tag_cnt_q == MAX_CNT) begin
								tag_open_d = 1'b0;
							end else begin
								store_we  = 1'b1;
								tag_cnt_d = tag_cnt_q + 1'b1;
								if (tag_cnt_d == MAX_CNT) begin
									tag_open_d = 1'b0;
								end
							end
						end
					end
					PH_ARGS: begin
						if (cur_kind == TAG_STRING) begin
							if (wbc_q == 2'd0) begin
								str_start_d = pos_q;
								wbc_d       = 2'd1;
							end
							if (data_byte == CH_NUL) begin
								arg_v   = 1'b1;
								advance = 1'b1;
								arg_res.kind       = KIND_STRING;
								arg_res.value_word = 32'(start);
							end
						end else begin
							word_d = word_new;
							wbc_d  = wbc_q + 1'b1;
							if (wbc_q == 2'd3) begin
								arg_v   = 1'b1;
								advance = 1'b1;
								arg_res.kind = (cur_kind == TAG_FLOAT) ? KIND_FLOAT : KIND_INT;
							end
						end
						if (advance) begin
							cur_arg_d = cur_arg_q + 1'b1;
							word_d    = '0;
							wbc_d     = 2'd0;
							if (cur_arg_d >= tag_cnt_q) begin
								phase_d = PH_DONE;
							end else begin
								phase_d = aligned ? PH_ARGS : PH_PAD;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign cur_ext_d = 32'(cur_arg_d);

	always_comb begin
		fin_res = '{kind: KIND_REJECT, arg_number: cur_ext_d[3:0], value_word: 32'd0,
			last_result: 1'b1};
		if (phase_d == PH_DONE) begin
			fin_res.kind       = KIND_ACCEPT;
			fin_res.value_word = 32'(tag_off_d);
		end
	end

	always_comb begin
		res0      = arg_v ? arg_res : fin_res;
		res1      = fin_res;
		res_count = 2'd0;
		if (beat_valid) begin
			res_count = 2'(arg_v) + 2'(end_of_packet);
		end
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			tag_store_q[tag_cnt_q[IDX_W-1:0]] <= store_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ADDR;
			pos_q       <= '0;
			tag_cnt_q   <= '0;
			tag_open_q  <= 1'b1;
			cur_arg_q   <= '0;
			word_q      <= '0;
			wbc_q       <= 2'd0;
			str_start_q <= '0;
			tag_off_q   <= '0;
		end else if (beat_valid && end_of_packet) begin
			phase_q     <= PH_ADDR;
			pos_q       <= '0;
			tag_cnt_q   <= '0;
			tag_open_q  <= 1'b1;
			cur_arg_q   <= '0;
			word_q      <= '0;
			wbc_q       <= 2'd0;
			str_start_q <= '0;
			tag_off_q   <= '0;
		end else begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			tag_cnt_q   <= tag_cnt_d;
			tag_open_q  <= tag_open_d;
			cur_arg_q   <= cur_arg_d;
			word_q      <= word_d;
			wbc_q       <= wbc_d;
			str_start_q <= str_start_d;
			tag_off_q   <= tag_off_d;
		end
	end

endmodule

// ===== rtl/core/osp_res_fifo.sv =====
module osp_res_fifo import osp_pkg::*; #(
	parameter int Depth = RES_FIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [1:0]                 push_count,
	input  res_t                       push0,
	input  res_t                       push1,
	input  logic                       pop,
	output res_t                       head,
	output logic                       not_empty,
	output logic [$clog2(Depth+1)-1:0] level
);

	localparam int PTR_W = $clog2(Depth);
	localparam int LVL_W = $clog2(Depth + 1);

	res_t             mem_q [Depth];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_nx;
	logic [LVL_W-1:0] level_q;

	assign wr_ptr_nx = wr_ptr_q + 1'b1;
	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (level_q != '0);
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_ptr_nx] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			level_q <= level_q + LVL_W'(push_count) - LVL_W'(pop);
		end
	end

endmodule
